@@ sv/mpa_pkg.sv @@
package mpa_pkg;

   // Default sizes
   localparam int DEF_CELLS        = 4096;
   localparam int DEF_MAX_CHANNELS = 64;

   // Field widths
   localparam int SAMPLE_W     = 32;
   localparam int INDEX_W      = 12;
   localparam int POS_W        = 24;
   localparam int ADDR_OUT_W   = 12;
   localparam int DIM_W        = 9;
   localparam int CHAN_CFG_W   = 7;
   localparam int STRIDE_CFG_W = 4;
   localparam int PAD_W        = 3;
   localparam int ROW_W        = 8;
   localparam int COL_W        = 8;

   // Row and column quotients come out one bit per cycle
   localparam int DIV_STEPS = DIM_W;
   // Width of pooled_row * pooled_width + pooled_col
   localparam int PROD1_W   = 2 * DIM_W + 1;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [SAMPLE_W-1:0] MOST_NEG = 32'h8000_0000;

   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      REG_IN_HEIGHT,
      REG_IN_WIDTH,
      REG_CHANNELS,
      REG_POOLED_WIDTH,
      REG_STRIDE_ROWS,
      REG_STRIDE_COLS,
      REG_PAD_TOP,
      REG_PAD_LEFT
   } mpa_reg_type;

   typedef struct packed {
      logic [DIM_W-1:0]        in_height;
      logic [DIM_W-1:0]        in_width;
      logic [CHAN_CFG_W-1:0]   channels;
      logic [DIM_W-1:0]        pooled_width;
      logic [STRIDE_CFG_W-1:0] stride_rows;
      logic [STRIDE_CFG_W-1:0] stride_cols;
      logic [PAD_W-1:0]        pad_top;
      logic [PAD_W-1:0]        pad_left;
   } mpa_cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_MUL1,
      ST_MUL2,
      ST_READ,
      ST_UPDATE
   } mpa_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic mul1;
      logic mul2;
      logic mem_read;
      logic update;
      logic clear_write;
   } mpa_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } mpa_status_type;

endpackage

@@ sv/mpa_ctrl.sv @@
module mpa_ctrl import mpa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tuser,
   output logic           req_tready,
   input  mpa_status_type status,
   output mpa_cmd_type    cmd
);

   localparam int STEP_W = $clog2(DIV_STEPS + 1);

   mpa_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              div_last;

   assign div_last = (step_ff == STEP_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = (req_tuser == OP_READ) ? ST_READ : ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = ST_MUL1;
         end
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_READ;
         ST_READ:  state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // count steps while staying in the divide state, restart on any move
   always_comb begin
      if (state_ff == ST_DIV && state_in == ST_DIV) begin
         step_in = step_ff + STEP_W'(1);
      end else begin
         step_in = '0;
      end
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_write = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_DIV:    cmd.div_step = 1'b1;
         ST_MUL1:   cmd.mul1 = 1'b1;
         ST_MUL2:   cmd.mul2 = 1'b1;
         ST_READ:   cmd.mem_read = 1'b1;
         ST_UPDATE: cmd.update = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ sv/mpa_datapath.sv @@
module mpa_datapath import mpa_pkg::*; #(
   parameter int CELLS        = DEF_CELLS,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpa_cmd_type           cmd,
   output mpa_status_type        status,
   input  mpa_cfg_type           cfg,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int AW    = $clog2(CELLS);
   localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CLW   = $clog2(MAX_CHANNELS + 1);
   localparam int CMPW  = (CLW > CHAN_CFG_W) ? CLW : CHAN_CFG_W;
   localparam int CAW   = (AW > ADDR_OUT_W) ? AW : ADDR_OUT_W;
   localparam int MEM_W = SAMPLE_W + POS_W;

   // clamped limits
   logic [DIM_W-1:0]        h_lim, w_lim;
   logic [CLW-1:0]          c_lim;
   logic [CMPW-1:0]         ch_ext;
   logic [STRIDE_CFG_W-1:0] sr, sc;

   always_comb begin
      h_lim  = (cfg.in_height == '0) ? DIM_W'(1) :
               (cfg.in_height > DIM_W'(256)) ? DIM_W'(256) : cfg.in_height;
      w_lim  = (cfg.in_width == '0) ? DIM_W'(1) :
               (cfg.in_width > DIM_W'(256)) ? DIM_W'(256) : cfg.in_width;
      ch_ext = CMPW'(cfg.channels);
      if (ch_ext == '0) begin
         c_lim = CLW'(1);
      end else if (ch_ext > CMPW'(MAX_CHANNELS)) begin
         c_lim = CLW'(MAX_CHANNELS);
      end else begin
         c_lim = CLW'(ch_ext);
      end
      sr = (cfg.stride_rows == '0) ? STRIDE_CFG_W'(1) : cfg.stride_rows;
      sc = (cfg.stride_cols == '0) ? STRIDE_CFG_W'(1) : cfg.stride_cols;
   end

   // item registers
   logic                op_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   // restoring dividers, quotient shifts in from the bottom of the dividend
   logic [DIM_W-1:0]        rnum_ff, rnum_in, cnum_ff, cnum_in;
   logic [STRIDE_CFG_W-1:0] rrem_ff, rrem_in, crem_ff, crem_in;
   logic [STRIDE_CFG_W:0]   r_trial, c_trial;
   logic                    r_ge, c_ge;

   always_comb begin
      r_trial = {rrem_ff, rnum_ff[DIM_W-1]};
      c_trial = {crem_ff, cnum_ff[DIM_W-1]};
      r_ge    = (r_trial >= {1'b0, sr});
      c_ge    = (c_trial >= {1'b0, sc});
      rrem_in = r_ge ? STRIDE_CFG_W'(r_trial - {1'b0, sr}) : r_trial[STRIDE_CFG_W-1:0];
      crem_in = c_ge ? STRIDE_CFG_W'(c_trial - {1'b0, sc}) : c_trial[STRIDE_CFG_W-1:0];
      rnum_in = {rnum_ff[DIM_W-2:0], r_ge};
      cnum_in = {cnum_ff[DIM_W-2:0], c_ge};
   end

   // cell index arithmetic; CELLS is a power of two, so keep the low bits
   logic [2*DIM_W-1:0]     prod_rc;
   logic [PROD1_W-1:0]     prod1_ff, prod1_in;
   logic [PROD1_W+CLW-1:0] prod_ch;
   logic [AW-1:0]          mrem_ff;

   always_comb begin
      prod_rc  = rnum_ff * cfg.pooled_width;
      prod1_in = PROD1_W'(prod_rc) + PROD1_W'(cnum_ff);
      prod_ch  = prod1_ff * c_lim;
   end

   // walk counters
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic [CHW-1:0]   chan_ff;
   logic [POS_W-1:0] pix_ff, pix_new;
   logic [CLW:0]     chan_inc;
   logic [DIM_W-1:0] col_inc, row_inc;

   always_comb begin
      pix_new  = (chan_ff == '0) ? pix_ff + POS_W'(1) : pix_ff;
      chan_inc = (CLW+1)'(chan_ff) + (CLW+1)'(1);
      col_inc  = DIM_W'(col_ff) + DIM_W'(1);
      row_inc  = DIM_W'(row_ff) + DIM_W'(1);
   end

   // cell memory: {position, maximum}
   logic [MEM_W-1:0]    mem [CELLS];
   logic [MEM_W-1:0]    rd_ff;
   logic [AW-1:0]       clr_ptr_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   logic [MEM_W-1:0]    mem_wd;
   logic [SAMPLE_W-1:0] stored_max;
   logic [POS_W-1:0]    stored_pos;
   logic                win;

   always_comb begin
      stored_max = rd_ff[SAMPLE_W-1:0];
      stored_pos = rd_ff[MEM_W-1:SAMPLE_W];
      win        = !op_ff && ($signed(sample_ff) > $signed(stored_max));
      mem_we     = cmd.clear_write || (cmd.update && (op_ff || win));
      mem_wa     = cmd.clear_write ? clr_ptr_ff : mrem_ff;
      mem_wd     = (cmd.clear_write || op_ff) ? {POS_W'(0), MOST_NEG} : {pix_new, sample_ff};
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.mem_read) rd_ff <= mem[mrem_ff];
   end

   // result register
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_upd_ff;
   logic [CAW-1:0]        addr_ext;
   logic [SAMPLE_W-1:0]   res_max;
   logic [POS_W-1:0]      res_pos;

   always_comb begin
      addr_ext    = CAW'(mrem_ff);
      res_max     = win ? sample_ff : stored_max;
      res_pos     = win ? pix_new : stored_pos;
      out_data_in = RSP_DATA_W'({res_pos, res_max, addr_ext[ADDR_OUT_W-1:0]});
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_tuser;
         sample_ff <= req_tdata[SAMPLE_W-1:0];
         rnum_ff   <= DIM_W'(row_ff) + DIM_W'(cfg.pad_top);
         cnum_ff   <= DIM_W'(col_ff) + DIM_W'(cfg.pad_left);
         rrem_ff   <= '0;
         crem_ff   <= '0;
         mrem_ff   <= AW'(req_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W]);
      end
      if (cmd.div_step) begin
         rnum_ff <= rnum_in;
         cnum_ff <= cnum_in;
         rrem_ff <= rrem_in;
         crem_ff <= crem_in;
      end
      if (cmd.mul1) prod1_ff <= prod1_in;
      if (cmd.mul2) mrem_ff <= AW'(prod_ch) + AW'(chan_ff);
      if (cmd.update) begin
         out_data_ff <= out_data_in;
         out_upd_ff  <= win;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         chan_ff      <= '0;
         pix_ff       <= '0;
      end else begin
         if (cmd.clear_write) clr_ptr_ff <= clr_ptr_ff + AW'(1);
         if (cmd.update) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.update && !op_ff) begin
            pix_ff <= pix_new;
            if (chan_inc >= (CLW+1)'(c_lim)) begin
               chan_ff <= '0;
               if (col_inc >= w_lim) begin
                  col_ff <= '0;
                  row_ff <= (row_inc >= h_lim) ? '0 : ROW_W'(row_inc);
               end else begin
                  col_ff <= COL_W'(col_inc);
               end
            end else begin
               chan_ff <= CHW'(chan_inc);
            end
         end
      end
   end

   assign status.clear_last = (clr_ptr_ff == AW'(CELLS - 1));
   assign status.out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid        = out_valid_ff;
   assign rsp_tdata         = out_data_ff;
   assign rsp_tuser         = out_upd_ff;

endmodule

@@ sv/max_pool_with_argmax.sv @@
// Streaming 2-D max pooling with argmax. Push samples in row, column,
// channel order (tuser 0); each one lands in pooled cell
// ((row+pad_top)/stride_rows*pooled_width + (col+pad_left)/stride_cols)
// * channels + channel, modulo CELLS, and replaces the stored maximum only
// when strictly greater, recording the running 1-based pixel number
// (24 bits, never reset between maps) as the argmax. A read (tuser 1)
// returns a cell and clears it. Every transfer in gives one transfer out.
// CELLS must be a power of two: the cell index keeps its low bits.
// After reset the block sweeps the cell memory, one cell per cycle,
// through all CELLS cells (4096 by default) before it raises req_tready;
// the APB registers are writable during that pass. Items are handled
// one at a time: a push passes through the accept cycle, bit-serial
// row/column division by the strides, the row-by-width and channel
// multiplies, one memory read and one read-modify-write; a read passes
// through accept, memory read and read-modify-write. A finished result
// waits in its own output register, so the next item is taken while it
// is still pending; the read-modify-write step holds while an earlier
// result still sits there unaccepted.
module max_pool_with_argmax import mpa_pkg::*; #(
   parameter int CELLS        = DEF_CELLS,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   // slave side
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // sample[31:0], cell_index[43:32], zero pad
   input  logic                  req_tuser,  // opcode
   // master side
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // cell_addr[11:0], cell_max[43:12],
                                             // cell_position[67:44], zero pad
   output logic                  rsp_tuser,  // updated
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   mpa_cfg_type    cfg_ff, cfg_in;
   mpa_cmd_type    cmd;
   mpa_status_type status;
   mpa_reg_type    reg_sel;
   logic           csr_write;

   // Register file: word-aligned, one register per 32-bit slot.
   assign csr_pready = 1'b1;
   assign reg_sel    = mpa_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_IN_HEIGHT:    cfg_in.in_height    = csr_pwdata[DIM_W-1:0];
            REG_IN_WIDTH:     cfg_in.in_width     = csr_pwdata[DIM_W-1:0];
            REG_CHANNELS:     cfg_in.channels     = csr_pwdata[CHAN_CFG_W-1:0];
            REG_POOLED_WIDTH: cfg_in.pooled_width = csr_pwdata[DIM_W-1:0];
            REG_STRIDE_ROWS:  cfg_in.stride_rows  = csr_pwdata[STRIDE_CFG_W-1:0];
            REG_STRIDE_COLS:  cfg_in.stride_cols  = csr_pwdata[STRIDE_CFG_W-1:0];
            REG_PAD_TOP:      cfg_in.pad_top      = csr_pwdata[PAD_W-1:0];
            REG_PAD_LEFT:     cfg_in.pad_left     = csr_pwdata[PAD_W-1:0];
         endcase
      end
   end

   // Read back the addressed register, zero extended.
   always_comb begin
      unique case (reg_sel)
         REG_IN_HEIGHT:    csr_prdata = CSR_DATA_W'(cfg_ff.in_height);
         REG_IN_WIDTH:     csr_prdata = CSR_DATA_W'(cfg_ff.in_width);
         REG_CHANNELS:     csr_prdata = CSR_DATA_W'(cfg_ff.channels);
         REG_POOLED_WIDTH: csr_prdata = CSR_DATA_W'(cfg_ff.pooled_width);
         REG_STRIDE_ROWS:  csr_prdata = CSR_DATA_W'(cfg_ff.stride_rows);
         REG_STRIDE_COLS:  csr_prdata = CSR_DATA_W'(cfg_ff.stride_cols);
         REG_PAD_TOP:      csr_prdata = CSR_DATA_W'(cfg_ff.pad_top);
         REG_PAD_LEFT:     csr_prdata = CSR_DATA_W'(cfg_ff.pad_left);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_height    <= DIM_W'(1);
         cfg_ff.in_width     <= DIM_W'(1);
         cfg_ff.channels     <= CHAN_CFG_W'(1);
         cfg_ff.pooled_width <= DIM_W'(1);
         cfg_ff.stride_rows  <= STRIDE_CFG_W'(1);
         cfg_ff.stride_cols  <= STRIDE_CFG_W'(1);
         cfg_ff.pad_top      <= '0;
         cfg_ff.pad_left     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer: owns the state and step count, issues at most one command a cycle.
   mpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Dividers, multipliers, cell memory, walk counters and the result
   // register.
   mpa_datapath #(
      .CELLS        (CELLS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // The sequencer never issues two commands in one cycle.
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command active");

   // Drop ready right after taking an item.
   assert property (@(posedge clock) disable iff (reset) cmd.accept |=> !req_tready)
      else $error("input still ready after a transfer was taken");

   // A finished item always shows up on the result side.
   assert property (@(posedge clock) disable iff (reset) cmd.update |=> rsp_tvalid)
      else $error("update did not load the result register");

   // A winning sample is strictly above the most negative value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[ADDR_OUT_W+SAMPLE_W-1:ADDR_OUT_W] != MOST_NEG))
      else $error("updated flag set with most negative maximum");

endmodule
